// ===== sv/ntcb_pkg.sv =====
package ntcb_pkg;

  // shared divider geometry
  localparam int DIV_W  = 64;
  localparam int DSR_W  = 56;
  localparam int NBITS_W = 7;

  typedef struct packed {
    logic               go;
    logic [NBITS_W-1:0] nbits;
  } div_req_t;

  localparam logic [23:0] LN2_Q24  = 24'd11629080;
  localparam logic [23:0] RES_MAX  = 24'hFFFFFF;
  localparam logic [16:0] TK_MAX   = 17'd100000;

  // register indexes
  localparam logic [2:0] REG_BETA   = 3'd0;
  localparam logic [2:0] REG_R0     = 3'd1;
  localparam logic [2:0] REG_T0     = 3'd2;
  localparam logic [2:0] REG_R1     = 3'd3;
  localparam logic [2:0] REG_SUPPLY = 3'd4;
  localparam logic [2:0] REG_NSAMP  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_SUPPLY = 2'd2;
  localparam logic [1:0] ST_LOG    = 2'd3;

endpackage

// ===== sv/ntcb_div.sv =====
module ntcb_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ntcb_pkg::div_req_t             req,
  input  logic [ntcb_pkg::DIV_W-1:0]     dividend,
  input  logic [ntcb_pkg::DSR_W-1:0]     divisor,
  output logic                           done,
  output logic [ntcb_pkg::DIV_W-1:0]     quotient
);
  import ntcb_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [NBITS_W-1:0]   cnt_r;
  logic [DIV_W-1:0]     q_r;
  logic [DSR_W-1:0]     rem_r;
  logic [DSR_W-1:0]     dsr_r;

  logic [DSR_W:0]       rs;
  logic                 ge;

  // one restoring step per cycle, dividend bits enter from the top of q_r
  assign rs = {rem_r, q_r[DIV_W-1]};
  assign ge = rs >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
        q_r    <= dividend << (NBITS_W'(DIV_W) - req.nbits);
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DSR_W'(rs - {1'b0, dsr_r}) : rs[DSR_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - NBITS_W'(1);
        if (cnt_r == NBITS_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== sv/ntc_beta_temperature_core.sv =====
// ntc thermistor temperature core, beta equation
// a word that does not close a group is only added to the accumulator; a closing word
//   starts the mean, resistance, log and temperature steps
// one word at a time: in_stall is high from a closing word until its result is loaded;
//   the result uses the shared serial divider (one quotient bit a cycle) and multiplier
// reset: synchronous active-low rst_n clears accumulator, sequencer and output valid,
//   and loads the default configuration
module ntc_beta_temperature_core #(
  parameter int LOG_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_sample_millivolts,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_mean_millivolts,
  output logic [23:0]        out_resistance_ohm,
  output logic [16:0]        out_temp_centikelvin,
  output logic signed [17:0] out_temp_centicelsius,
  output logic signed [18:0] out_temp_centifahrenheit,
  output logic [1:0]         out_status,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  import ntcb_pkg::*;

  // iteration counter is at least 6 bits so the q32 bit position test works
  localparam int ITER_W = ($clog2(LOG_ITERATIONS + 1) > 6) ? $clog2(LOG_ITERATIONS + 1) : 6;

  // reciprocal of ten, exact for any 32-bit dividend after a 35-bit shift
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_MEAN_GO  = 5'd1;
  localparam logic [4:0] S_MEAN_WT  = 5'd2;
  localparam logic [4:0] S_CHECK    = 5'd3;
  localparam logic [4:0] S_RES_MUL  = 5'd4;
  localparam logic [4:0] S_RES_GO   = 5'd5;
  localparam logic [4:0] S_RES_WT   = 5'd6;
  localparam logic [4:0] S_LOG_NORM = 5'd7;
  localparam logic [4:0] S_LOG_MUL  = 5'd8;
  localparam logic [4:0] S_LOG_SQ   = 5'd9;
  localparam logic [4:0] S_LOG_END  = 5'd10;
  localparam logic [4:0] S_LN_LO    = 5'd11;
  localparam logic [4:0] S_LN_HI    = 5'd12;
  localparam logic [4:0] S_LN_SUM   = 5'd13;
  localparam logic [4:0] S_BQ_GO    = 5'd14;
  localparam logic [4:0] S_BQ_WT    = 5'd15;
  localparam logic [4:0] S_DENOM    = 5'd16;
  localparam logic [4:0] S_TK_GO    = 5'd17;
  localparam logic [4:0] S_TK_WT    = 5'd18;
  localparam logic [4:0] S_CF_MUL   = 5'd19;
  localparam logic [4:0] S_CF_SHIFT = 5'd20;
  localparam logic [4:0] S_DONE     = 5'd21;

  // configuration registers
  logic [13:0] beta_r;
  logic [19:0] r0_r;
  logic [15:0] t0_r;
  logic [19:0] r1_r;
  logic [12:0] supply_r;
  logic [4:0]  nsamp_r;

  // accumulator
  logic [15:0] sum_r;
  logic [4:0]  cnt_r;
  logic [15:0] grp_sum_r;
  logic [4:0]  grp_cnt_r;

  // sequencer and datapath
  logic [4:0]        state_r;
  logic [11:0]       mean_r;
  logic [23:0]       res_r;
  logic [1:0]        status_r;
  logic [63:0]       prod_r;
  logic [55:0]       acc_r;
  logic [30:0]       m_r;
  logic [4:0]        exp_r;
  logic [31:0]       frac_r;
  logic [ITER_W-1:0] iter_r;
  logic              log_sel_r;
  logic [36:0]       lr_r;
  logic [36:0]       mag_r;
  logic              neg_r;
  logic [36:0]       lnq_r;
  logic [52:0]       bq_r;
  logic [53:0]       ud_r;
  logic [16:0]       tk_r;
  logic [18:0]       cf_r;

  // output registers
  logic              out_valid_r;
  logic [11:0]       out_mean_r;
  logic [23:0]       out_res_r;
  logic [16:0]       out_tk_r;
  logic signed [17:0] out_tc_r;
  logic signed [18:0] out_tf_r;
  logic [1:0]        out_status_r;

  // shared multiplier operands
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // divider hookup
  div_req_t    div_req;
  logic [63:0] div_dividend;
  logic [55:0] div_divisor;
  logic        div_done;
  logic [63:0] div_q;

  // helpers
  logic [4:0]  grp_n;
  logic [15:0] acc_sum;
  logic [4:0]  acc_cnt;
  logic        in_take;
  logic        out_load;
  logic [19:0] r0_eff;
  logic [15:0] t0_eff;
  logic [36:0] log_val;
  logic [31:0] sq;
  logic [61:0] ln_sum;
  logic [20:0] bq_num;
  logic [27:0] tk_num;
  logic [20:0] cf_num;

  assign in_take = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // group size zero counts as one, above sixteen as sixteen
  assign grp_n   = (nsamp_r == 5'd0) ? 5'd1 : ((nsamp_r > 5'd16) ? 5'd16 : nsamp_r);
  assign acc_sum = sum_r + 16'(in_sample_millivolts);
  assign acc_cnt = cnt_r + 5'd1;

  assign r0_eff  = (r0_r == 20'd0) ? 20'd1 : r0_r;
  assign t0_eff  = (t0_r == 16'd0) ? 16'd1 : t0_r;
  assign log_val = {exp_r, frac_r};
  assign sq      = prod_r[61:30];
  assign ln_sum  = {6'd0, acc_r} + {prod_r[29:0], 32'd0};
  assign bq_num  = 21'(beta_r) * 21'd100;
  assign tk_num  = 28'(beta_r) * 28'd10000;
  assign cf_num  = 21'(tk_r) * 21'd18 + 21'd5;

  // result register frees up when taken or empty
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RES_MUL: begin
        mul_a = 32'(r1_r);
        mul_b = 32'(supply_r - 13'(mean_r));
      end
      S_LOG_MUL: begin
        mul_a = 32'(m_r);
        mul_b = 32'(m_r);
      end
      S_LN_LO: begin
        mul_a = mag_r[31:0];
        mul_b = 32'(LN2_Q24);
      end
      S_LN_HI: begin
        mul_a = 32'(mag_r[36:32]);
        mul_b = 32'(LN2_Q24);
      end
      S_CF_MUL: begin
        mul_a = 32'(cf_num);
        mul_b = RECIP10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider request per state
  always_comb begin
    div_req      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_r)
      S_MEAN_GO: begin
        div_req.go    = 1'b1;
        div_req.nbits = NBITS_W'(16);
        div_dividend  = 64'(grp_sum_r);
        div_divisor   = 56'(grp_cnt_r);
      end
      S_RES_GO: begin
        div_req.go    = 1'b1;
        div_req.nbits = NBITS_W'(34);
        div_dividend  = 64'(prod_r[33:0]);
        div_divisor   = 56'(mean_r);
      end
      S_BQ_GO: begin
        div_req.go    = 1'b1;
        div_req.nbits = NBITS_W'(53);
        div_dividend  = 64'({bq_num, 32'd0});
        div_divisor   = 56'(t0_eff);
      end
      S_TK_GO: begin
        // rounded quotient: add half the divisor first
        div_req.go    = 1'b1;
        div_req.nbits = NBITS_W'(64);
        div_dividend  = 64'({tk_num, 32'd0}) + 64'(ud_r[53:1]);
        div_divisor   = 56'(ud_r);
      end
      default: begin
        div_req      = '0;
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  ntcb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r   <= 14'd3950;
      r0_r     <= 20'd100000;
      t0_r     <= 16'd29815;
      r1_r     <= 20'd10000;
      supply_r <= 13'd3300;
      nsamp_r  <= 5'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BETA:   beta_r   <= cfg_data[13:0];
        REG_R0:     r0_r     <= cfg_data;
        REG_T0:     t0_r     <= cfg_data[15:0];
        REG_R1:     r1_r     <= cfg_data;
        REG_SUPPLY: supply_r <= cfg_data[12:0];
        REG_NSAMP:  nsamp_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (acc_cnt < grp_n) begin
              sum_r <= acc_sum;
              cnt_r <= acc_cnt;
            end else begin
              // group closes: latch it and start over
              grp_sum_r <= acc_sum;
              grp_cnt_r <= acc_cnt;
              sum_r     <= '0;
              cnt_r     <= '0;
              state_r   <= S_MEAN_GO;
            end
          end
        end
        S_MEAN_GO: state_r <= S_MEAN_WT;
        S_MEAN_WT: begin
          if (div_done) begin
            mean_r  <= (div_q[15:0] > 16'd4095) ? 12'd4095 : div_q[11:0];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (mean_r == 12'd0) begin
            status_r <= ST_ZERO;
            res_r    <= RES_MAX;
            state_r  <= S_DONE;
          end else if (13'(mean_r) >= supply_r) begin
            status_r <= ST_SUPPLY;
            res_r    <= '0;
            state_r  <= S_DONE;
          end else begin
            status_r <= ST_OK;
            state_r  <= S_RES_MUL;
          end
        end
        S_RES_MUL: begin
          prod_r  <= 64'(mul_a) * 64'(mul_b);
          state_r <= S_RES_GO;
        end
        S_RES_GO: state_r <= S_RES_WT;
        S_RES_WT: begin
          if (div_done) begin
            if (div_q > 64'(RES_MAX)) begin
              res_r <= RES_MAX;
              m_r   <= {RES_MAX, 7'd0};
            end else begin
              res_r <= div_q[23:0];
              m_r   <= {div_q[23:0], 7'd0};
            end
            exp_r     <= 5'd23;
            frac_r    <= '0;
            iter_r    <= '0;
            log_sel_r <= 1'b0;
            if (div_q == 64'd0) begin
              status_r <= ST_LOG;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_LOG_NORM;
            end
          end
        end
        S_LOG_NORM: begin
          // one bit a cycle until the leading one sits at bit 30
          if (m_r[30]) begin
            state_r <= S_LOG_MUL;
          end else begin
            m_r   <= {m_r[29:0], 1'b0};
            exp_r <= exp_r - 5'd1;
          end
        end
        S_LOG_MUL: begin
          prod_r  <= 64'(mul_a) * 64'(mul_b);
          state_r <= S_LOG_SQ;
        end
        S_LOG_SQ: begin
          if (sq[31]) begin
            m_r <= sq[31:1];
            if (iter_r < ITER_W'(32)) begin
              frac_r[5'd31 - iter_r[4:0]] <= 1'b1;
            end
          end else begin
            m_r <= sq[30:0];
          end
          iter_r <= iter_r + ITER_W'(1);
          if (iter_r == ITER_W'(LOG_ITERATIONS - 1)) begin
            state_r <= S_LOG_END;
          end else begin
            state_r <= S_LOG_MUL;
          end
        end
        S_LOG_END: begin
          if (!log_sel_r) begin
            // thermistor log done, now the nominal resistance
            lr_r      <= log_val;
            m_r       <= {4'd0, r0_eff, 7'd0};
            exp_r     <= 5'd23;
            frac_r    <= '0;
            iter_r    <= '0;
            log_sel_r <= 1'b1;
            state_r   <= S_LOG_NORM;
          end else begin
            neg_r   <= lr_r < log_val;
            mag_r   <= (lr_r < log_val) ? (log_val - lr_r) : (lr_r - log_val);
            state_r <= S_LN_LO;
          end
        end
        S_LN_LO: begin
          prod_r  <= 64'(mul_a) * 64'(mul_b);
          state_r <= S_LN_HI;
        end
        S_LN_HI: begin
          acc_r   <= prod_r[55:0];
          prod_r  <= 64'(mul_a) * 64'(mul_b);
          state_r <= S_LN_SUM;
        end
        S_LN_SUM: begin
          lnq_r   <= ln_sum[60:24];
          state_r <= S_BQ_GO;
        end
        S_BQ_GO: state_r <= S_BQ_WT;
        S_BQ_WT: begin
          if (div_done) begin
            bq_r    <= div_q[52:0];
            state_r <= S_DENOM;
          end
        end
        S_DENOM: begin
          // denominator ln(R/R0) + beta/T0 must stay positive
          if (neg_r ? (53'(lnq_r) >= bq_r) : ((bq_r == 53'd0) && (lnq_r == 37'd0))) begin
            status_r <= ST_LOG;
            state_r  <= S_DONE;
          end else begin
            ud_r    <= neg_r ? 54'(bq_r - 53'(lnq_r)) : (54'(bq_r) + 54'(lnq_r));
            state_r <= S_TK_GO;
          end
        end
        S_TK_GO: state_r <= S_TK_WT;
        S_TK_WT: begin
          if (div_done) begin
            tk_r    <= (div_q > 64'(TK_MAX)) ? TK_MAX : div_q[16:0];
            state_r <= S_CF_MUL;
          end
        end
        S_CF_MUL: begin
          // divide by ten through the reciprocal
          prod_r  <= 64'(mul_a) * 64'(mul_b);
          state_r <= S_CF_SHIFT;
        end
        S_CF_SHIFT: begin
          cf_r    <= 19'(prod_r[55:35]) - 19'd45940;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register, temperatures forced to zero on any fault
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_r   <= mean_r;
      out_res_r    <= res_r;
      out_status_r <= status_r;
      if (status_r == ST_OK) begin
        out_tk_r <= tk_r;
        out_tc_r <= $signed({1'b0, tk_r}) - 18'sd27300;
        out_tf_r <= $signed(cf_r);
      end else begin
        out_tk_r <= '0;
        out_tc_r <= '0;
        out_tf_r <= '0;
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_mean_millivolts      = out_mean_r;
  assign out_resistance_ohm       = out_res_r;
  assign out_temp_centikelvin     = out_tk_r;
  assign out_temp_centicelsius    = out_tc_r;
  assign out_temp_centifahrenheit = out_tf_r;
  assign out_status               = out_status_r;

endmodule

// ===== tb/ntc_beta_temperature_core_test.sv =====
module ntc_beta_temperature_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ntcb_pkg::*;

  localparam int LOG_ITERS = 24;
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic [11:0]        mean;
    logic [23:0]        res;
    logic [16:0]        tk;
    logic signed [17:0] tc;
    logic signed [18:0] tf;
    logic [1:0]         status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_sample_millivolts = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] out_mean_millivolts;
  logic [23:0] out_resistance_ohm;
  logic [16:0] out_temp_centikelvin;
  logic signed [17:0] out_temp_centicelsius;
  logic signed [18:0] out_temp_centifahrenheit;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  ntc_beta_temperature_core #(.LOG_ITERATIONS(LOG_ITERS)) DUT (.*);

  // predictor copy of configuration and accumulator
  logic [13:0] beta_k;
  logic [19:0] r0_ohm;
  logic [15:0] t0_ck;
  logic [19:0] series_ohm;
  logic [12:0] supply_mv;
  logic [4:0]  group_size;
  logic [15:0] acc_sum;
  logic [4:0]  acc_count;

  logic [11:0] sample_queue[$];
  reading_t    reading_queue[$];

  // edge voltages for single-sample groups
  int directed_mv[8] = '{0, 4095, 3300, 3299, 1, 1650, 2048, 300};

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_sender = 1'b0;
  bit in_fire = 1'b0;
  int mismatches = 0;
  int readings_seen = 0;
  int samples_sent = 0;
  int status_seen[4];

  initial begin
    forever #4 clk = ~clk;
  end

  // log2 of x as unsigned Q32, squaring iteration on a Q30 mantissa
  function automatic logic [63:0] log2_fixed(input logic [23:0] x_in);
    logic [23:0] x;
    logic [63:0] mant;
    logic [63:0] frac;
    int e;
    x = x_in;
    e = 0;
    frac = '0;
    if (x == 0) x = 24'd1;
    while (e < 23 && (x >> (e + 1)) != 0) e++;
    mant = 64'(x) << (30 - e);
    for (int i = 0; i < LOG_ITERS; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    if (LOG_ITERS >= 32) frac = frac >> (LOG_ITERS - 32);
    else frac = frac << (32 - LOG_ITERS);
    return (64'(e) << 32) + frac;
  endfunction

  // closes a group: mean, divider resistance and beta temperature
  function automatic reading_t thermistor_reading(input logic [15:0] sum, input logic [4:0] cnt);
    reading_t r;
    logic [31:0] mean32;
    logic [63:0] res, tk, r0, t0, lr, l0, mag, lnq, bq, ud, num;
    logic signed [64:0] d;
    bit neg;
    r = '0;
    mean32 = sum / ((cnt == 0) ? 32'd1 : 32'(cnt));
    if (mean32 > 4095) mean32 = 4095;
    r.mean = mean32[11:0];
    if (mean32 == 0) begin
      r.status = ST_ZERO;
      r.res = RES_MAX;
    end else if (mean32 >= 32'(supply_mv)) begin
      r.status = ST_SUPPLY;
    end else begin
      res = 64'(series_ohm) * 64'(32'(supply_mv) - mean32) / 64'(mean32);
      if (res > 64'(RES_MAX)) res = 64'(RES_MAX);
      r.res = res[23:0];
      if (res == 0) begin
        r.status = ST_LOG;
      end else begin
        r0 = (r0_ohm == 0) ? 64'd1 : 64'(r0_ohm);
        t0 = (t0_ck == 0) ? 64'd1 : 64'(t0_ck);
        lr = log2_fixed(res[23:0]);
        l0 = log2_fixed(r0[23:0]);
        neg = lr < l0;
        mag = neg ? l0 - lr : lr - l0;
        lnq = (mag * 64'(LN2_Q24)) >> 24;
        bq = ((64'(beta_k) * 100) << 32) / t0;
        d = neg ? $signed({1'b0, bq}) - $signed({1'b0, lnq})
                : $signed({1'b0, bq}) + $signed({1'b0, lnq});
        if (d <= 0) begin
          r.status = ST_LOG;
        end else begin
          ud = d[63:0];
          num = (64'(beta_k) * 10000) << 32;
          tk = (num + ud / 2) / ud;
          if (tk > 64'(TK_MAX)) tk = 64'(TK_MAX);
          r.status = ST_OK;
          r.tk = tk[16:0];
          r.tc = 18'(tk - 27300);
          r.tf = 19'((tk * 18 + 5) / 10 - 45940);
        end
      end
    end
    return r;
  endfunction

  // driver: one word from the sample queue, changes on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (sample_queue.size() > 0 && !hold_sender &&
            $urandom_range(99, 0) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_sample_millivolts <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_sample_millivolts <= 12'($urandom);
        end
      end
      out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
    end
  end

  // accepted samples feed the predictor; accepted results are checked
  always @(posedge clk) begin
    logic [4:0] n;
    reading_t got, want;
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n = (group_size == 0) ? 5'd1 : (group_size > 16) ? 5'd16 : group_size;
        samples_sent++;
        acc_sum = acc_sum + 16'(in_sample_millivolts);
        acc_count = acc_count + 5'd1;
        if (acc_count >= n) begin
          reading_queue.push_back(thermistor_reading(acc_sum, acc_count));
          acc_sum = '0;
          acc_count = '0;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_mean_millivolts, out_resistance_ohm, out_temp_centikelvin,
                out_temp_centicelsius, out_temp_centifahrenheit, out_status};
        readings_seen++;
        if (reading_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          want = reading_queue.pop_front();
          status_seen[want.status]++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BETA:   beta_k = val[13:0];
      REG_R0:     r0_ohm = val;
      REG_T0:     t0_ck = val[15:0];
      REG_R1:     series_ohm = val;
      REG_SUPPLY: supply_mv = val[12:0];
      default:    group_size = val[4:0];
    endcase
  endtask

  // wait for queue drain and every result, then settle so a partial group is idle
  task automatic drain_all();
    while (sample_queue.size() > 0 || in_valid || reading_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample anywhere from 1 mV to the supply, plus edges near zero, at the supply and random
  function automatic logic [11:0] pick_sample();
    int k;
    k = $urandom_range(9, 0);
    if (k == 0) return 12'($urandom);
    if (k == 1) return 12'($urandom_range(3, 0));
    if (k == 2) return 12'(supply_mv) + 12'($urandom_range(2, 0));
    return 12'($urandom_range((supply_mv > 4095) ? 4095 : supply_mv, 1));
  endfunction

  task automatic random_phase(input int items, input int idle, input int stall);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    repeat (items) sample_queue.push_back(pick_sample());
    drain_all();
  endtask

  initial begin
    beta_k = 14'd3950; r0_ohm = 20'd100000; t0_ck = 16'd29815;
    series_ohm = 20'd10000; supply_mv = 13'd3300; group_size = 5'd5;
    acc_sum = '0; acc_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: reset config, single-sample groups for edge voltages
    write_reg(REG_NSAMP, 20'd1);
    foreach (directed_mv[i])
      sample_queue.push_back(12'(directed_mv[i]));
    drain_all();
    // group size zero behaves as one, size above 16 clamps to 16
    write_reg(REG_NSAMP, 20'd0);
    sample_queue.push_back(12'd1000);
    sample_queue.push_back(12'd1001);
    drain_all();
    write_reg(REG_NSAMP, 20'd31);
    repeat (16) sample_queue.push_back(12'd4095);
    drain_all();
    // group size lowered mid-group closes at the next sample
    write_reg(REG_NSAMP, 20'd8);
    repeat (3) sample_queue.push_back(12'd1200);
    drain_all();
    write_reg(REG_NSAMP, 20'd2);
    sample_queue.push_back(12'd900);
    drain_all();
    // log not positive: tiny beta over huge T0 with R far below a large R0
    write_reg(REG_BETA, 20'd1000);
    write_reg(REG_T0, 20'd40000);
    write_reg(REG_R0, 20'd1000000);
    write_reg(REG_R1, 20'd100);
    write_reg(REG_SUPPLY, 20'd5000);
    write_reg(REG_NSAMP, 20'd1);
    sample_queue.push_back(12'd4000);
    sample_queue.push_back(12'd10);
    drain_all();
    // zero registers are used as one
    write_reg(REG_R0, 20'd0);
    write_reg(REG_T0, 20'd0);
    sample_queue.push_back(12'd2500);
    drain_all();

    // random phases across configurations, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BETA, 20'd3950); write_reg(REG_R0, 20'd100000);
          write_reg(REG_T0, 20'd29815); write_reg(REG_R1, 20'd10000);
          write_reg(REG_SUPPLY, 20'd3300); write_reg(REG_NSAMP, 20'd1);
        end
        1: begin
          write_reg(REG_BETA, 20'd10000); write_reg(REG_R0, 20'd100);
          write_reg(REG_T0, 20'd20000); write_reg(REG_R1, 20'd1000000);
          write_reg(REG_SUPPLY, 20'd1000); write_reg(REG_NSAMP, 20'd16);
        end
        2: begin
          write_reg(REG_BETA, 20'd16383); write_reg(REG_R0, 20'hFFFFF);
          write_reg(REG_T0, 20'hFFFF); write_reg(REG_R1, 20'hFFFFF);
          write_reg(REG_SUPPLY, 20'h1FFF); write_reg(REG_NSAMP, 20'd3);
        end
        default: begin
          write_reg(REG_BETA, 20'($urandom_range(10000, 1000)));
          write_reg(REG_R0, 20'($urandom_range(1000000, 100)));
          write_reg(REG_T0, 20'($urandom_range(40000, 20000)));
          write_reg(REG_R1, 20'($urandom_range(1000000, 100)));
          write_reg(REG_SUPPLY, 20'($urandom_range(5000, 1000)));
          write_reg(REG_NSAMP, 20'($urandom_range(4, 1)));
        end
      endcase
      case (ph % 4)
        0: random_phase(190, 0, 0);
        1: random_phase(190, 60, 0);
        2: random_phase(190, 0, 60);
        default: random_phase(190, 7, 7);
      endcase
      // sender holds off until every result is home
      if (ph == 3) begin
        hold_sender = 1'b1;
        repeat (20) sample_queue.push_back(pick_sample());
        while (reading_queue.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
        drain_all();
      end
    end

    $display("covered %0d samples, %0d results across 8 random phases", samples_sent,
             readings_seen);
    $display("status ok %0d, zero %0d, high %0d, bad log %0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && reading_queue.size() == 0) begin
      $display("[ntc_beta_temperature_core] OK");
    end else begin
      $display("[ntc_beta_temperature_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("[ntc_beta_temperature_core] ERROR");
    $finish;
  end
endmodule

// ===== ntc_beta_temperature_core.f =====
sv/ntcb_pkg.sv
sv/ntcb_div.sv
sv/ntc_beta_temperature_core.sv
tb/ntc_beta_temperature_core_test.sv
